// File: hw/rtl/msdd_pkg.sv
// Shared types and constants for the modulated stereo delay doubler.
package msdd_pkg;

    // Sample and register field widths.
    localparam int SAMPLE_BITS = 24;
    localparam int MIX_W       = 17;
    localparam int LAG_W       = 20;
    localparam int LAG_FRAC    = 8;
    localparam int WOB_W       = 16;
    localparam int STEP_W      = 32;
    localparam int FRAC_W      = 16;

    // Delay in Q16 samples: lag shifted up, plus one bit of modulation headroom.
    localparam int D_W         = LAG_W + LAG_FRAC + 1;
    localparam int DI_W        = D_W - FRAC_W;

    // Shared multiplier and accumulator.
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = SAMPLE_BITS;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 60;
    localparam int WOBP_W      = LAG_W + WOB_W;
    localparam int WOBP_SPLIT  = 18;
    localparam int MOD_SHIFT   = 32;

    localparam logic [MIX_W-1:0] Q16_ONE = 17'h10000;

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Sine table construction, Q30 quarter-wave polynomial.
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_DIVS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    localparam logic [63:0] SINE_ROUND  = 64'd64;
    localparam int          SINE_SHIFT  = 7;
    localparam logic [63:0] SINE_MAX    = 64'd8388607;

    typedef enum logic [1:0] {
        REG_MIX    = 2'd0,
        REG_LAG    = 2'd1,
        REG_WOBBLE = 2'd2,
        REG_STEP   = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SINE,
        ST_WOBBLE,
        ST_MOD_LO,
        ST_MOD_HI,
        ST_MOD_SUM,
        ST_DELAY,
        ST_WRAP,
        ST_POS,
        ST_RD0,
        ST_RD1,
        ST_WET_L0,
        ST_WET_L1,
        ST_WET_R0,
        ST_WET_R1,
        ST_MIX_L0,
        ST_MIX_L1,
        ST_MIX_R0,
        ST_MIX_R1,
        ST_MIX_END,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SHIFT_ADD
    } t_acc_op;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_beat;

endpackage

// File: hw/rtl/modulated_stereo_delay_doubler_top.sv
// Modulated stereo delay doubler: delay stores, LFO, interpolation and mix on one shared MAC.
//
//  Channel   Direction  Handshake                       Payload
//  in        input      i_in_valid / o_in_ready         i_in_data  (left_in, right_in)
//  out       output     o_out_valid / i_out_ready       o_out_data (left_out, right_out)
//  config    input      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// After a frame is accepted the block is busy until its result is registered and takes no new
// frame meanwhile; the delay is wrapped into the store by J_MAX + 1 compare-subtract steps.
// The single 32x24 multiplier and its accumulator carry all twelve products.
// After reset a clearing pass zeroes all DELAY_DEPTH entries of both stores, one entry per cycle;
// no frame is accepted meanwhile. A result waits in the output register while the next frame
// is taken; a frame only stalls at its last step if the previous result has not been taken.
module modulated_stereo_delay_doubler_top #(
    parameter int DELAY_DEPTH  = 4096,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  msdd_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output msdd_pkg::t_out_beat           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msdd_pkg::APB_AW-1:0]   paddr,
    input  logic [msdd_pkg::APB_DW-1:0]   pwdata,
    output logic [msdd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import msdd_pkg::*;

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int KW      = $clog2(SINE_ENTRIES);
    localparam int J_MAX   = (DI_W > AW) ? (DI_W - AW) : 0;
    localparam int MSTEP_W = (J_MAX > 0) ? $clog2(J_MAX + 1) : 1;
    localparam int MW      = ((DI_W > AW) ? DI_W : AW) + 1;

    typedef logic [SAMPLE_BITS-1:0] t_sine_rom [SINE_ENTRIES];

    // Builds sin(2*pi*k/SINE_ENTRIES) in Q1.23 from the quarter-wave polynomial.
    function automatic t_sine_rom f_build_sine();
        t_sine_rom   rom;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] res;
        logic [63:0] val;
        logic [1:0]  q;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            p = (64'(k) << 32) / 64'(SINE_ENTRIES);
            p = {32'h0, p[31:0]};
            q = p[31:30];
            r = {34'h0, p[29:0]};
            if (q[0]) begin
                r = Q30_ONE - r;
            end
            x  = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int i = 0; i < 5; i++) begin
                t = Q30_ONE - (((x2 * t) >> 30) / SINE_DIVS[i]);
            end
            res = (x * t) >> 30;
            val = (res + SINE_ROUND) >> SINE_SHIFT;
            if (val > SINE_MAX) begin
                val = SINE_MAX;
            end
            rom[k] = q[1] ? SAMPLE_BITS'(64'd0 - val) : SAMPLE_BITS'(val);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

    // Signed sample to offset-binary, so that blends run on unsigned products.
    function automatic logic [SAMPLE_BITS-1:0] f_ua(input logic [SAMPLE_BITS-1:0] s);
        return {~s[SAMPLE_BITS-1], s[SAMPLE_BITS-2:0]};
    endfunction

    // Takes the Q16 blend sum back to a signed sample, saturating at the top.
    function automatic logic [SAMPLE_BITS-1:0] f_unblend(input logic [ACC_W-1:0] acc);
        logic [SAMPLE_BITS:0] u;
        u = acc[FRAC_W +: SAMPLE_BITS+1];
        if (u[SAMPLE_BITS]) begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return {~u[SAMPLE_BITS-1], u[SAMPLE_BITS-2:0]};
    endfunction

    // Control state.
    t_state                 r_state;
    t_state                 n_state;
    logic [AW-1:0]          r_clr_addr;
    logic [AW-1:0]          r_wp;
    logic [STEP_W-1:0]      r_phase;
    logic                   r_out_valid;

    // Configuration registers.
    logic [MIX_W-1:0]       r_mix;
    logic [LAG_W-1:0]       r_lag;
    logic [WOB_W-1:0]       r_wob;
    logic [STEP_W-1:0]      r_step;

    // Datapath registers.
    logic [SAMPLE_BITS-1:0] r_l_in;
    logic [SAMPLE_BITS-1:0] r_r_in;
    logic [PROD_W-1:0]      r_prod;
    logic [ACC_W-1:0]       r_acc;
    logic [SAMPLE_BITS-1:0] r_sine;
    logic [SAMPLE_BITS-2:0] r_mag;
    logic                   r_neg;
    logic [WOBP_W-1:0]      r_pw;
    logic [DI_W-1:0]        r_rem;
    logic [FRAC_W-1:0]      r_df;
    logic [MSTEP_W-1:0]     r_mstep;
    logic [AW-1:0]          r_i0;
    logic [FRAC_W-1:0]      r_frac;
    logic [SAMPLE_BITS-1:0] r_la;
    logic [SAMPLE_BITS-1:0] r_ra;
    logic [SAMPLE_BITS-1:0] r_lq;
    logic [SAMPLE_BITS-1:0] r_rq;
    logic [SAMPLE_BITS-1:0] r_wet_l;
    logic [SAMPLE_BITS-1:0] r_wet_r;
    logic [SAMPLE_BITS-1:0] r_res_l;
    t_out_beat              r_out_data;

    logic [SAMPLE_BITS-1:0] r_store_l [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] r_store_r [DELAY_DEPTH];

    // Combinational control and datapath.
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    t_acc_op                acc_op;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [AW-1:0]          i1;
    logic [KW-1:0]          rom_k;
    logic [MIX_W-1:0]       mix_c;
    logic [MIX_W-1:0]       mix_inv;
    logic [MIX_W-1:0]       frac_inv;
    logic [D_W-1:0]         delay_base;
    logic [D_W-1:0]         delay_mod;
    logic [D_W-1:0]         delay_q16;
    logic [MW-1:0]          wrap_cmp;
    logic [AW:0]            pos_diff;
    logic                   out_free;
    logic                   cfg_wr;

    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite & pready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || i_out_ready;

    assign i1       = (r_i0 == AW'(DELAY_DEPTH - 1)) ? '0 : r_i0 + AW'(1);
    assign rom_k    = r_prod[MOD_SHIFT +: KW];
    assign mix_c    = (r_mix > Q16_ONE) ? Q16_ONE : r_mix;
    assign mix_inv  = Q16_ONE - mix_c;
    assign frac_inv = Q16_ONE - MIX_W'(r_frac);

    // The modulation never exceeds the base delay, so the clamp to zero is a guard only.
    assign delay_base = D_W'({r_lag, {LAG_FRAC{1'b0}}});
    assign delay_mod  = D_W'(r_acc[MOD_SHIFT +: D_W-1]);
    always_comb begin
        if (!r_neg) begin
            delay_q16 = delay_base + delay_mod;
        end else if (delay_mod > delay_base) begin
            delay_q16 = '0;
        end else begin
            delay_q16 = delay_base - delay_mod;
        end
    end

    assign wrap_cmp = MW'(DELAY_DEPTH) << r_mstep;

    // Integer read position; a nonzero fraction borrows one more entry.
    assign pos_diff = {1'b0, r_wp} - (AW+1)'(AW'(r_rem)) - (AW+1)'(|r_df);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DELAY_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE:   n_state = ST_SINE;
            ST_SINE:    n_state = ST_WOBBLE;
            ST_WOBBLE:  n_state = ST_MOD_LO;
            ST_MOD_LO:  n_state = ST_MOD_HI;
            ST_MOD_HI:  n_state = ST_MOD_SUM;
            ST_MOD_SUM: n_state = ST_DELAY;
            ST_DELAY:   n_state = ST_WRAP;
            ST_WRAP: begin
                if (r_mstep == '0) begin
                    n_state = ST_POS;
                end
            end
            ST_POS:     n_state = ST_RD0;
            ST_RD0:     n_state = ST_RD1;
            ST_RD1:     n_state = ST_WET_L0;
            ST_WET_L0:  n_state = ST_WET_L1;
            ST_WET_L1:  n_state = ST_WET_R0;
            ST_WET_R0:  n_state = ST_WET_R1;
            ST_WET_R1:  n_state = ST_MIX_L0;
            ST_MIX_L0:  n_state = ST_MIX_L1;
            ST_MIX_L1:  n_state = ST_MIX_R0;
            ST_MIX_R0:  n_state = ST_MIX_R1;
            ST_MIX_R1:  n_state = ST_MIX_END;
            ST_MIX_END: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Operand selection for the shared multiplier, accumulator op and store port.
    // A product issued in one state is accumulated in the next.
    // The store port rests on the upper neighbor, so its read data holds through the blends.
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        acc_op   = ACC_HOLD;
        mem_we   = 1'b0;
        mem_addr = i1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            ST_IDLE: begin
            end
            ST_WRITE: begin
                mem_we   = 1'b1;
                mem_addr = r_wp;
                mul_a    = MUL_A_W'(r_phase);
                mul_b    = MUL_B_W'(SINE_ENTRIES);
            end
            ST_SINE: begin
                mul_a = MUL_A_W'(r_lag);
                mul_b = MUL_B_W'(r_wob);
            end
            ST_WOBBLE: begin
            end
            ST_MOD_LO: begin
                mul_a = MUL_A_W'(r_pw[WOBP_W-1:WOBP_SPLIT]);
                mul_b = MUL_B_W'(r_mag);
            end
            ST_MOD_HI: begin
                acc_op = ACC_LOAD;
                mul_a  = MUL_A_W'(r_pw[WOBP_SPLIT-1:0]);
                mul_b  = MUL_B_W'(r_mag);
            end
            ST_MOD_SUM: begin
                acc_op = ACC_SHIFT_ADD;
            end
            ST_DELAY, ST_WRAP, ST_POS: begin
            end
            ST_RD0: begin
                mem_addr = r_i0;
            end
            ST_RD1: begin
                mem_addr = i1;
            end
            ST_WET_L0: begin
                mul_a = MUL_A_W'(frac_inv);
                mul_b = f_ua(r_la);
            end
            ST_WET_L1: begin
                acc_op = ACC_LOAD;
                mul_a  = MUL_A_W'(r_frac);
                mul_b  = f_ua(r_lq);
            end
            ST_WET_R0: begin
                acc_op = ACC_ADD;
                mul_a  = MUL_A_W'(frac_inv);
                mul_b  = f_ua(r_ra);
            end
            ST_WET_R1: begin
                acc_op = ACC_LOAD;
                mul_a  = MUL_A_W'(r_frac);
                mul_b  = f_ua(r_rq);
            end
            ST_MIX_L0: begin
                acc_op = ACC_ADD;
                mul_a  = MUL_A_W'(mix_inv);
                mul_b  = f_ua(r_l_in);
            end
            ST_MIX_L1: begin
                acc_op = ACC_LOAD;
                mul_a  = MUL_A_W'(mix_c);
                mul_b  = f_ua(r_wet_l);
            end
            ST_MIX_R0: begin
                acc_op = ACC_ADD;
                mul_a  = MUL_A_W'(mix_inv);
                mul_b  = f_ua(r_r_in);
            end
            ST_MIX_R1: begin
                acc_op = ACC_LOAD;
                mul_a  = MUL_A_W'(mix_c);
                mul_b  = f_ua(r_wet_r);
            end
            ST_MIX_END: begin
                acc_op = ACC_ADD;
            end
            ST_DONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_mix       <= MIX_W'(32768);
            r_lag       <= LAG_W'(245760);
            r_wob       <= '0;
            r_step      <= STEP_W'(22370);
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == ST_SINE) begin
                r_phase <= r_phase + r_step;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_wp        <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_MIX:    r_mix  <= pwdata[MIX_W-1:0];
                    REG_LAG:    r_lag  <= pwdata[LAG_W-1:0];
                    REG_WOBBLE: r_wob  <= pwdata[WOB_W-1:0];
                    REG_STEP:   r_step <= pwdata[STEP_W-1:0];
                endcase
            end
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[APB_AW-1:2]))
            REG_MIX:    prdata = APB_DW'(r_mix);
            REG_LAG:    prdata = APB_DW'(r_lag);
            REG_WOBBLE: prdata = APB_DW'(r_wob);
            REG_STEP:   prdata = APB_DW'(r_step);
        endcase
    end

    // Shared multiplier with a registered product, then the accumulator.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (acc_op)
            ACC_LOAD:      r_acc <= ACC_W'(r_prod);
            ACC_ADD:       r_acc <= r_acc + ACC_W'(r_prod);
            ACC_SHIFT_ADD: r_acc <= (r_acc << WOBP_SPLIT) + ACC_W'(r_prod);
            default:       r_acc <= r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_l_in <= i_in_data.left_in;
            r_r_in <= i_in_data.right_in;
        end
        if (r_state == ST_SINE) begin
            r_sine <= SINE_ROM[rom_k];
        end
        if (r_state == ST_WOBBLE) begin
            r_mag <= (SAMPLE_BITS-1)'(r_sine[SAMPLE_BITS-1] ? ('0 - r_sine) : r_sine);
            r_neg <= r_sine[SAMPLE_BITS-1];
            r_pw  <= r_prod[WOBP_W-1:0];
        end
        if (r_state == ST_DELAY) begin
            r_rem   <= delay_q16[FRAC_W +: DI_W];
            r_df    <= delay_q16[FRAC_W-1:0];
            r_mstep <= MSTEP_W'(J_MAX);
        end
        // One restoring step per cycle takes the integer delay modulo the depth.
        if (r_state == ST_WRAP) begin
            if (MW'(r_rem) >= wrap_cmp) begin
                r_rem <= DI_W'(MW'(r_rem) - wrap_cmp);
            end
            r_mstep <= r_mstep - MSTEP_W'(1);
        end
        if (r_state == ST_POS) begin
            r_i0   <= pos_diff[AW] ? AW'(pos_diff + (AW+1)'(DELAY_DEPTH)) : pos_diff[AW-1:0];
            r_frac <= '0 - r_df;
        end
        if (r_state == ST_RD1) begin
            r_la <= r_lq;
            r_ra <= r_rq;
        end
        if (r_state == ST_WET_R1) begin
            r_wet_l <= f_unblend(r_acc);
        end
        if (r_state == ST_MIX_L1) begin
            r_wet_r <= f_unblend(r_acc);
        end
        if (r_state == ST_MIX_R1) begin
            r_res_l <= f_unblend(r_acc);
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_data.left_out  <= r_res_l;
            r_out_data.right_out <= f_unblend(r_acc);
        end
    end

    // Delay stores: one port each, shared by the clearing pass, the write and both reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store_l[mem_addr] <= (r_state == ST_CLEAR) ? '0 : r_l_in;
            r_store_r[mem_addr] <= (r_state == ST_CLEAR) ? '0 : r_r_in;
        end
        r_lq <= r_store_l[mem_addr];
        r_rq <= r_store_r[mem_addr];
    end

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD0) |-> (r_i0 <= AW'(DELAY_DEPTH - 1)))
        else $error("read index beyond the delay store");

    a_wrap_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POS) |-> (MW'(r_rem) < MW'(DELAY_DEPTH)))
        else $error("delay not reduced below the store depth");

    a_delay_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELAY && r_neg) |-> (delay_mod <= delay_base))
        else $error("modulation deeper than the base delay");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the final step");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_CLEAR)
            |-> ($past(r_clr_addr) == AW'(DELAY_DEPTH - 1)))
        else $error("clearing pass ended early");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the modulated stereo delay doubler, with its own frame predictor.
`timescale 1ns / 100ps

module tb_top;
    import msdd_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int SINE_N    = 1024;
    localparam int SETTLE    = 40;
    localparam int LONG_HOLD = 300;
    localparam int RAND_SETS = 6;
    localparam int PER_SET   = 150;
    localparam longint unsigned SPAN      = 64'd1 << 28;
    localparam longint unsigned Q30       = 64'd1073741824;
    localparam longint unsigned HALF_PI   = 64'd1686629713;
    localparam longint          HALF_FS   = 64'sd8388608;
    localparam longint          POS_LIMIT = 64'sd8388607;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    t_in_beat            in_data = '0;
    logic                out_ready = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_beat           o_out_data;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Shadow copy of the voicing registers and the effect state.
    logic [MIX_W-1:0]    mix_cfg  = 17'd32768;
    logic [LAG_W-1:0]    lag_cfg  = 20'd245760;
    logic [WOB_W-1:0]    wob_cfg  = 16'd0;
    logic [STEP_W-1:0]   step_cfg = 32'd22370;
    int                  left_store [DEPTH];
    int                  right_store [DEPTH];
    int unsigned         wr_ptr = 0;
    logic [31:0]         lfo_acc = '0;
    int                  sine_tab [SINE_N];

    t_in_beat            frame_queue [$];
    t_out_beat           expected_out [$];
    int                  errors = 0;
    int unsigned         send_gap = 0;
    int unsigned         hold_left = 0;
    logic                hold_toggle = 1'b0;
    logic                hold_seen = 1'b0;
    logic                calm = 1'b0;

    modulated_stereo_delay_doubler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Quarter-wave odd polynomial in Q30, folded to a full cycle and rounded to Q1.23.
    function automatic int sine_point(int unsigned k);
        longint unsigned div_by [5] = '{110, 72, 42, 20, 6};
        int unsigned     p;
        int unsigned     quad;
        longint unsigned r, x, x2, t, res, val;
        p    = k << 22;
        quad = p >> 30;
        r    = p & 32'h3FFF_FFFF;
        if (quad[0]) begin
            r = Q30 - r;
        end
        x  = (r * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30;
        for (int i = 0; i < 5; i++) begin
            t = Q30 - ((x2 * t) >> 30) / div_by[i];
        end
        res = (x * t) >> 30;
        val = (res + 64) >> 7;
        if (val > 64'd8388607) begin
            val = 64'd8388607;
        end
        return (quad >= 2) ? -int'(val) : int'(val);
    endfunction

    // Weighted blend in Q16: floor((a*(1-w) + b*w)), done on offset-binary samples.
    function automatic longint lerp_q16(longint a, longint b, longint unsigned w);
        longint unsigned ua, ub, acc;
        ua  = longint'(a + HALF_FS);
        ub  = longint'(b + HALF_FS);
        acc = ua * (64'd65536 - w) + ub * w;
        return longint'(acc >> 16) - HALF_FS;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(longint v);
        if (v > POS_LIMIT) begin
            v = POS_LIMIT;
        end
        if (v < -HALF_FS) begin
            v = -HALF_FS;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Writes one frame into the stores and returns the mixed output it produces.
    function automatic t_out_beat doubler_frame(t_in_beat beat);
        t_out_beat       result;
        longint          l, r, s, d, dl, dr;
        longint unsigned mag, modv, dm, pos, frac, mixv;
        int unsigned     wp, i0, i1;
        l  = beat.left_in;
        r  = beat.right_in;
        wp = wr_ptr;
        s  = sine_tab[lfo_acc[31:22]];
        mag  = (s < 0) ? longint'(-s) : longint'(s);
        modv = (longint'(lag_cfg) * longint'(wob_cfg) * mag) >> 32;
        left_store[wp]  = int'(l);
        right_store[wp] = int'(r);
        d = longint'(lag_cfg) << 8;
        d = (s < 0) ? d - longint'(modv) : d + longint'(modv);
        if (d < 0) begin
            d = 0;
        end
        dm   = longint'(d) % SPAN;
        pos  = ((longint'(wp) << 16) + SPAN - dm) % SPAN;
        i0   = int'(pos >> 16) % DEPTH;
        i1   = (i0 + 1) % DEPTH;
        frac = pos & 64'hFFFF;
        dl = lerp_q16(left_store[i0], left_store[i1], frac);
        dr = lerp_q16(right_store[i0], right_store[i1], frac);
        mixv = (mix_cfg > 17'd65536) ? 64'd65536 : longint'(mix_cfg);
        result.left_out  = clip_sample(lerp_q16(l, dl, mixv));
        result.right_out = clip_sample(lerp_q16(r, dr, mixv));
        wr_ptr  = (wp + 1) % DEPTH;
        lfo_acc = lfo_acc + step_cfg;
        return result;
    endfunction

    task automatic flag_error(input string what, input logic [SAMPLE_BITS-1:0] got,
                              input logic [SAMPLE_BITS-1:0] want);
        errors++;
        $display("%0t ns mismatch on %s: got %0d expected %0d", $time, what,
                 $signed(got), $signed(want));
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIX:    mix_cfg  = val[MIX_W-1:0];
            REG_LAG:    lag_cfg  = val[LAG_W-1:0];
            REG_WOBBLE: wob_cfg  = val[WOB_W-1:0];
            REG_STEP:   step_cfg = val[STEP_W-1:0];
        endcase
    endtask

    task automatic program_voicing(input logic [31:0] mix, input logic [31:0] lag,
                                   input logic [31:0] wob, input logic [31:0] step);
        apb_write(REG_MIX, mix);
        apb_write(REG_LAG, lag);
        apb_write(REG_WOBBLE, wob);
        apb_write(REG_STEP, step);
    endtask

    task automatic queue_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
        t_in_beat beat;
        beat.left_in  = l;
        beat.right_in = r;
        frame_queue.push_back(beat);
    endtask

    // Returns once every queued frame went in and every result came back, plus a margin.
    task automatic wait_drained();
        @(negedge i_clk);
        while (frame_queue.size() != 0 || in_valid || expected_out.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($signed($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    // Frame sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (frame_queue.size() != 0) begin
                in_data  <= frame_queue.pop_front();
                in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    send_gap <= $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: short random stalls, and one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            hold_left <= $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Predict on every accepted input beat and compare every accepted output beat.
    always @(posedge i_clk) begin : frame_check
        t_out_beat want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                expected_out.push_back(doubler_frame(in_data));
            end
            if (o_out_valid && out_ready) begin
                if (expected_out.size() == 0) begin
                    flag_error("unexpected beat", o_out_data.left_out, '0);
                end else begin
                    want = expected_out.pop_front();
                    if (o_out_data.left_out !== want.left_out) begin
                        flag_error("left_out", o_out_data.left_out, want.left_out);
                    end
                    if (o_out_data.right_out !== want.right_out) begin
                        flag_error("right_out", o_out_data.right_out, want.right_out);
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] mix, lag, wob, step;
        for (int k = 0; k < SINE_N; k++) begin
            sine_tab[k] = sine_point(k);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The stores are cleared after reset; nothing is taken until that pass ends.
        @(negedge i_clk);
        while (o_in_ready !== 1'b1) begin
            @(negedge i_clk);
        end

        // Reset voicing, sample extremes and bit patterns.
        queue_frame(24'h7FFFFF, 24'h800000);
        queue_frame(24'h800000, 24'h7FFFFF);
        queue_frame(24'h000000, 24'h000000);
        queue_frame(24'hAAAAAA, 24'h555555);
        queue_frame(24'hFFFFFF, 24'h000001);
        wait_drained();

        // Zero delay with mix above full and a phase step that wraps every frame.
        program_voicing(32'd131071, 32'd0, 32'd65535, 32'hFFFF_FFFF);
        queue_frame(24'h7FFFFF, 24'h7FFFFF);
        queue_frame(24'h800000, 24'h800000);
        queue_frame(24'h555555, 24'hAAAAAA);
        queue_frame(24'h000001, 24'hFFFFFF);
        queue_frame(24'h123456, 24'hEDCBA9);
        queue_frame(24'h000000, 24'h7FFFFF);
        wait_drained();

        // Longest lag at full depth, quarter-turn LFO: the read position wraps the store.
        program_voicing(32'd65536, 32'd1048575, 32'd65535, 32'h4000_0000);
        for (int i = 0; i < 8; i++) begin
            queue_frame(pick_sample(), pick_sample());
        end
        wait_drained();

        // Fully dry, one-sample lag.
        program_voicing(32'd0, 32'd256, 32'd0, 32'd22370);
        for (int i = 0; i < 4; i++) begin
            queue_frame(pick_sample(), pick_sample());
        end
        wait_drained();

        for (int set = 0; set < RAND_SETS; set++) begin
            case ($urandom_range(0, 5))
                0:       mix = 0;
                1:       mix = 65536;
                2:       mix = $urandom_range(65537, 131071);
                default: mix = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 4))
                0:       lag = 0;
                1:       lag = 1048575;
                2:       lag = $urandom_range(0, 4095);
                default: lag = $urandom_range(0, 1048575);
            endcase
            case ($urandom_range(0, 3))
                0:       wob = 0;
                1:       wob = 65535;
                default: wob = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       step = 0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = $urandom_range(0, 32'h0010_0000);
                default: step = $urandom;
            endcase
            program_voicing(mix, lag, wob, step);
            if (set == RAND_SETS - 1) begin
                calm <= 1'b1;
            end
            for (int i = 0; i < PER_SET; i++) begin
                queue_frame(pick_sample(), pick_sample());
            end
            if (set == 1) begin
                // Receiver stops for a long stretch while frames keep coming.
                @(posedge i_clk);
                hold_toggle <= ~hold_toggle;
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: modulated_stereo_delay_doubler_top.f
hw/rtl/msdd_pkg.sv
hw/rtl/modulated_stereo_delay_doubler_top.sv
dv/tb_top.sv
